[design/lelm_pkg.sv]
`default_nettype none

package lelm_pkg;

    // Widths fixed by the transaction formats.
    localparam int ENTRY_W = 8;
    localparam int COUNT_W = 9;

    // Default size of the entry set.
    localparam int ENTRIES_DEFAULT = 256;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_UNLINK = 1'b1;

    typedef struct packed {
        logic               command;
        logic [ENTRY_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic               error;
        logic               front_valid;
        logic [ENTRY_W-1:0] front_entry;
        logic               rear_valid;
        logic [ENTRY_W-1:0] rear_entry;
        logic [COUNT_W-1:0] linked_count;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EVAL,
        S_CLEAR,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_wr;  // clear one link entry of the post-reset sweep
        logic capture;  // take the input transaction and read its links
        logic eval;     // decide and apply the neighbor updates
        logic clear;    // invalidate both links of the unlinked entry
        logic load;     // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;   // the sweep is at its last entry
        logic need_clear;  // the evaluated command unlinks a linked entry
        logic out_free;    // the output register can take a result now
    } t_status;

endpackage

`default_nettype wire

[design/lelm_ctrl.sv]
`default_nettype none

module lelm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire lelm_pkg::t_status i_status,
    output logic                   o_in_stall,
    output lelm_pkg::t_cmd         o_cmd
);

    lelm_pkg::t_state r_state;
    lelm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lelm_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            lelm_pkg::S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_status.init_last) begin
                    n_state = lelm_pkg::S_IDLE;
                end
            end
            lelm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lelm_pkg::S_EVAL;
                end
            end
            lelm_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_clear ? lelm_pkg::S_CLEAR : lelm_pkg::S_DONE;
            end
            lelm_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = lelm_pkg::S_DONE;
            end
            lelm_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = lelm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lelm_pkg::S_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/lelm_dp.sv]
`default_nettype none

module lelm_dp #(
    parameter int ENTRIES = lelm_pkg::ENTRIES_DEFAULT
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire lelm_pkg::t_cmd       i_cmd,
    input  wire lelm_pkg::t_in_item   i_in,
    input  wire                       i_out_stall,
    output lelm_pkg::t_status         o_status,
    output logic                      o_out_valid,
    output lelm_pkg::t_out_item       o_out
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LNK_W = IDX_W + 1;   // valid bit on top of an entry index

    // Link memories, one word per entry: {valid, index}.
    logic [LNK_W-1:0] next_mem [ENTRIES];
    logic [LNK_W-1:0] prev_mem [ENTRIES];

    logic [LNK_W-1:0] r_next_rd;
    logic [LNK_W-1:0] r_prev_rd;

    logic                         r_command;
    logic [lelm_pkg::ENTRY_W-1:0] r_entry;

    logic [IDX_W-1:0]             r_front;
    logic [IDX_W-1:0]             n_front;
    logic                         r_front_ok;
    logic                         n_front_ok;
    logic [IDX_W-1:0]             r_rear;
    logic [IDX_W-1:0]             n_rear;
    logic                         r_rear_ok;
    logic                         n_rear_ok;
    logic [lelm_pkg::COUNT_W-1:0] r_count;
    logic [lelm_pkg::COUNT_W-1:0] n_count;
    logic                         r_error;
    logic                         n_error;

    logic [IDX_W-1:0] r_init_addr;

    logic             r_out_valid;
    lelm_pkg::t_out_item r_out;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] e_idx;
    logic             in_range;
    logic             linked;
    logic             do_ins;
    logic             do_unl;
    logic             next_v;
    logic [IDX_W-1:0] next_l;
    logic             prev_v;
    logic [IDX_W-1:0] prev_l;

    logic             nx_we;
    logic [IDX_W-1:0] nx_wa;
    logic [LNK_W-1:0] nx_wd;
    logic             pv_we;
    logic [IDX_W-1:0] pv_wa;
    logic [LNK_W-1:0] pv_wd;

    assign rd_addr = IDX_W'(i_in.entry_index);
    assign e_idx   = IDX_W'(r_entry);
    assign next_v  = r_next_rd[LNK_W-1];
    assign next_l  = r_next_rd[IDX_W-1:0];
    assign prev_v  = r_prev_rd[LNK_W-1];
    assign prev_l  = r_prev_rd[IDX_W-1:0];

    // Indexes at or beyond the entry count are ignored.
    assign in_range = (32'(r_entry) < ENTRIES);
    // A lone entry has no valid links but is the front of the list.
    assign linked   = next_v || prev_v || (r_front_ok && (r_front == e_idx));
    assign do_ins   = in_range && (r_command == lelm_pkg::CMD_INSERT) && !linked;
    assign do_unl   = in_range && (r_command == lelm_pkg::CMD_UNLINK) && linked;

    // Memory write selection.
    always_comb begin
        nx_we = 1'b0;
        nx_wa = e_idx;
        nx_wd = '0;
        pv_we = 1'b0;
        pv_wa = e_idx;
        pv_wd = '0;
        if (i_cmd.init_wr) begin
            nx_we = 1'b1;
            nx_wa = r_init_addr;
            pv_we = 1'b1;
            pv_wa = r_init_addr;
        end else if (i_cmd.clear) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
        end else if (i_cmd.eval && do_ins) begin
            nx_we = 1'b1;
            nx_wd = {r_front_ok, r_front};
            pv_we = r_front_ok;
            pv_wa = r_front;
            pv_wd = {1'b1, e_idx};
        end else if (i_cmd.eval && do_unl) begin
            nx_we = prev_v;
            nx_wa = prev_l;
            nx_wd = {next_v, next_l};
            pv_we = next_v;
            pv_wa = next_l;
            pv_wd = {prev_v, prev_l};
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            next_mem[nx_wa] <= nx_wd;
        end
        if (i_cmd.capture) begin
            r_next_rd <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            prev_mem[pv_wa] <= pv_wd;
        end
        if (i_cmd.capture) begin
            r_prev_rd <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_in.command;
            r_entry   <= i_in.entry_index;
        end
    end

    // List head, tail and count.
    always_comb begin
        n_front    = r_front;
        n_front_ok = r_front_ok;
        n_rear     = r_rear;
        n_rear_ok  = r_rear_ok;
        n_count    = r_count;
        n_error    = r_error;
        if (i_cmd.eval) begin
            n_error = in_range && (r_command == lelm_pkg::CMD_INSERT) && linked;
            if (do_ins) begin
                n_count    = r_count + 1'b1;
                n_front    = e_idx;
                n_front_ok = 1'b1;
                if (!r_front_ok) begin
                    n_rear    = e_idx;
                    n_rear_ok = 1'b1;
                end
            end else if (do_unl) begin
                n_count = r_count - 1'b1;
                if (!next_v) begin
                    n_rear    = prev_l;
                    n_rear_ok = prev_v;
                end
                if (!prev_v) begin
                    n_front    = next_l;
                    n_front_ok = next_v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_ok  <= 1'b0;
            r_rear_ok   <= 1'b0;
            r_count     <= '0;
            r_init_addr <= '0;
        end else begin
            r_front_ok <= n_front_ok;
            r_rear_ok  <= n_rear_ok;
            r_count    <= n_count;
            if (i_cmd.init_wr) begin
                r_init_addr <= r_init_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_rear  <= n_rear;
        r_error <= n_error;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.error        <= r_error;
            r_out.front_valid  <= r_front_ok;
            r_out.front_entry  <= r_front_ok ? lelm_pkg::ENTRY_W'(r_front) : '0;
            r_out.rear_valid   <= r_rear_ok;
            r_out.rear_entry   <= r_rear_ok ? lelm_pkg::ENTRY_W'(r_rear) : '0;
            r_out.linked_count <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_status.init_last  = (r_init_addr == IDX_W'(ENTRIES - 1));
    assign o_status.need_clear = do_unl;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

[design/lru_entry_list_manager.sv]
`default_nettype none

// LRU entry list manager. The block keeps a doubly linked recency list over
// ENTRIES cache entries, from the most recently used entry (front) to the least
// recently used one (rear, the eviction candidate), and counts the linked
// entries. Each input transaction names an entry and a command: insert puts the
// entry at the front, unlink takes it out of the list wherever it sits. An insert
// of an entry that is already linked is refused with the error flag set, an
// unlink of an entry that is not linked changes nothing, and an index at or
// beyond ENTRIES is ignored. Every input transaction gives exactly one output
// transaction with the front, rear and count after the command. Items are
// handled one at a time. For an insert, a refused insert or an ignored command
// the transaction is captured, then evaluated, then its result is loaded into
// the output register. An unlink of a linked entry has a clear step between
// the evaluation and the load, because the unlink first reads the entry's
// links, then rewrites the neighbors' links, then invalidates the entry's own
// links, and each link memory has one write port. The next input transaction
// is accepted in the cycle after the result is loaded. The result may still
// wait in the output register while the next transaction is worked on; the
// load of that next result waits until the output register is free. After
// reset the block sweeps both link memories to invalidate every link, and
// holds o_in_stall high until the sweep is done.

module lru_entry_list_manager #(
    parameter int ENTRIES = lelm_pkg::ENTRIES_DEFAULT
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire lelm_pkg::t_in_item   i_in,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output lelm_pkg::t_out_item       o_out
);

    // Command and status between the sequencer and the list datapath.
    lelm_pkg::t_cmd    cmd;
    lelm_pkg::t_status status;

    lelm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lelm_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
